// ----- src/path_glob_matcher_core_assert.svh -----
// ----------------------------------------------------------------------------
// path glob matcher assertion macros
// concurrent checks used at the end of the top level
// ----------------------------------------------------------------------------
`ifndef PATH_GLOB_MATCHER_CORE_ASSERT_SVH
`define PATH_GLOB_MATCHER_CORE_ASSERT_SVH

// same-cycle implication
`define PGM_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("pgm check failed");

// next-cycle implication
`define PGM_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("pgm check failed");

`endif

// ----- src/pgm_pkg.sv -----
// ----------------------------------------------------------------------------
// path glob matcher package
// shared types, sizes, character codes and helpers
// ----------------------------------------------------------------------------
package pgm_pkg;

    localparam int PAT_DEPTH = 64;
    localparam int TXT_DEPTH = 256;
    localparam int PAT_AW    = $clog2(PAT_DEPTH);
    localparam int TXT_AW    = $clog2(TXT_DEPTH);
    localparam int PLEN_W    = PAT_AW + 1;
    localparam int TLEN_W    = TXT_AW + 1;
    localparam int OFS_W     = 7;
    localparam int J_W       = ((PLEN_W > OFS_W) ? PLEN_W : OFS_W) + 1;
    localparam int I_W       = ((TLEN_W > OFS_W) ? TLEN_W : OFS_W) + 1;

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_RBR   = 8'h5D;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef enum logic [1:0] {
        CMD_PAT_APPEND = 2'd0,
        CMD_TXT_APPEND = 2'd1,
        CMD_EVAL       = 2'd2,
        CMD_PAT_CLEAR  = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] char_byte;
    } in_item_t;

    typedef struct packed {
        logic matched;
        logic descend_candidate;
        logic overflow;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOOP,
        ST_CHAR,
        ST_ESC,
        ST_STAR2,
        ST_DSTAR,
        ST_CLS_NEG,
        ST_CLS,
        ST_CLS_RNG,
        ST_FAIL,
        ST_STAR_CHK,
        ST_DS_CHK,
        ST_DS_RD,
        ST_DS_TST,
        ST_TAIL_RD,
        ST_TAIL_TST,
        ST_DONE
    } state_t;

    typedef struct packed {
        state_t op;
        logic   load;
        logic   start;
        logic   out_load;
    } ctl_t;

    typedef struct packed {
        logic i_lt_n;
        logic j_lt_m;
        logic j1_lt_m;
        logic p_star;
        logic p_qm;
        logic p_lbr;
        logic p_bsl;
        logic p_slash;
        logic p_rbr;
        logic p_dash;
        logic t_slash;
        logic lit_eq;
        logic last_none;
        logic hit_eq_neg;
        logic star_ok;
        logic dstar_ok;
        logic dp_ge1;
        logic ds_lt_n;
    } sts_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UA && c <= CH_UZ)
        begin
            r = c + CASE_OFS;
        end
        return r;
    endfunction

endpackage

// ----- src/pgm_datapath.sv -----
// ----------------------------------------------------------------------------
// path glob matcher datapath
// pattern and text stores, scan pointers, backup points and result register
// ----------------------------------------------------------------------------
module pgm_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pgm_pkg::ctl_t        ctl,
    input  pgm_pkg::in_item_t    in_data,
    input  logic                 cfg_we,
    input  logic [6:0]           cfg_data,
    output pgm_pkg::sts_t        sts,
    output pgm_pkg::out_item_t   out_data
);
    import pgm_pkg::*;

    logic [7:0]        pmem [PAT_DEPTH];
    logic [7:0]        tmem [TXT_DEPTH];

    logic [PLEN_W-1:0] plen_reg;
    logic [TLEN_W-1:0] tlen_reg;
    logic              dropped_reg;
    logic [OFS_W-1:0]  ofs_reg;

    logic [7:0]        pdata_reg;
    logic              p_in_reg;
    logic [7:0]        tdata_reg;
    logic              t_in_reg;

    logic [I_W-1:0]    i_reg;
    logic [J_W-1:0]    j_reg;
    logic              star_ok_reg;
    logic              dstar_ok_reg;
    logic [I_W-1:0]    star_t_reg;
    logic [J_W-1:0]    star_p_reg;
    logic [I_W-1:0]    dstar_t_reg;
    logic [J_W-1:0]    dstar_p_reg;
    logic              neg_reg;
    logic              hit_reg;
    logic              last_none_reg;
    logic [7:0]        last_reg;
    logic              res_match_reg;
    logic              res_desc_reg;
    out_item_t         out_reg;

    logic [J_W-1:0]    p_addr;
    logic              p_rd;
    logic [I_W-1:0]    t_addr;
    logic              t_rd;
    logic [7:0]        pv;
    logic [7:0]        tv;
    logic [7:0]        lt;
    logic [7:0]        lp;
    logic [J_W-1:0]    j1;
    logic [J_W-1:0]    m_ext;
    logic [I_W-1:0]    n_ext;
    logic [I_W-1:0]    star_t_inc;
    logic [I_W-1:0]    dstar_t_inc;
    logic              neg_c;
    logic              n_zero;

    assign pv          = p_in_reg ? pdata_reg : 8'd0;
    assign tv          = t_in_reg ? tdata_reg : 8'd0;
    assign lt          = to_lower(tv);
    assign lp          = to_lower(pv);
    assign j1          = j_reg + J_W'(1);
    assign m_ext       = J_W'(plen_reg);
    assign n_ext       = I_W'(tlen_reg);
    assign star_t_inc  = star_t_reg + I_W'(1);
    assign dstar_t_inc = dstar_t_reg + I_W'(1);
    assign neg_c       = sts.j1_lt_m && (pv == CH_CARET || pv == CH_BANG);
    assign n_zero      = (tlen_reg == '0);

    assign sts.i_lt_n     = i_reg < n_ext;
    assign sts.j_lt_m     = j_reg < m_ext;
    assign sts.j1_lt_m    = j1 < m_ext;
    assign sts.p_star     = pv == CH_STAR;
    assign sts.p_qm       = pv == CH_QMARK;
    assign sts.p_lbr      = pv == CH_LBR;
    assign sts.p_bsl      = pv == CH_BSL;
    assign sts.p_slash    = pv == CH_SLASH;
    assign sts.p_rbr      = pv == CH_RBR;
    assign sts.p_dash     = pv == CH_DASH;
    assign sts.t_slash    = tv == CH_SLASH;
    assign sts.lit_eq     = lt == lp;
    assign sts.last_none  = last_none_reg;
    assign sts.hit_eq_neg = hit_reg == neg_reg;
    assign sts.star_ok    = star_ok_reg;
    assign sts.dstar_ok   = dstar_ok_reg;
    assign sts.dp_ge1     = dstar_p_reg != '0;
    assign sts.ds_lt_n    = dstar_t_reg < n_ext;

    assign out_data = out_reg;

    // read address selection
    always_comb
    begin
        p_addr = j_reg;
        p_rd   = 1'b0;
        t_addr = i_reg;
        t_rd   = 1'b0;
        case (ctl.op)
            ST_LOOP:
            begin
                p_rd = sts.i_lt_n && sts.j_lt_m;
                t_rd = sts.i_lt_n && sts.j_lt_m;
            end
            ST_CHAR, ST_CLS, ST_CLS_RNG:
            begin
                p_addr = j1;
                p_rd   = 1'b1;
            end
            ST_STAR2:
            begin
                p_addr = j1;
                p_rd   = 1'b1;
            end
            ST_CLS_NEG:
            begin
                p_addr = j1 + J_W'(neg_c);
                p_rd   = 1'b1;
            end
            ST_FAIL:
            begin
                t_addr = star_t_inc;
                t_rd   = star_ok_reg;
                p_addr = dstar_p_reg - J_W'(1);
                p_rd   = !star_ok_reg;
            end
            ST_DS_RD:
            begin
                t_addr = dstar_t_reg;
                t_rd   = 1'b1;
            end
            ST_TAIL_RD:
            begin
                p_rd = 1'b1;
            end
            default:
            begin
                p_rd = 1'b0;
            end
        endcase
    end

    // stores
    always_ff @(posedge clk)
    begin
        if (ctl.load && in_data.cmd == CMD_PAT_APPEND && plen_reg < PLEN_W'(PAT_DEPTH))
        begin
            pmem[plen_reg[PAT_AW-1:0]] <= in_data.char_byte;
        end
        if (ctl.load && in_data.cmd == CMD_TXT_APPEND && tlen_reg < TLEN_W'(TXT_DEPTH))
        begin
            tmem[tlen_reg[TXT_AW-1:0]] <= in_data.char_byte;
        end
        if (p_rd)
        begin
            pdata_reg <= pmem[p_addr[PAT_AW-1:0]];
            p_in_reg  <= p_addr < m_ext;
        end
        if (t_rd)
        begin
            tdata_reg <= tmem[t_addr[TXT_AW-1:0]];
            t_in_reg  <= t_addr < n_ext;
        end
    end

    // lengths, dropped flag, offset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg    <= '0;
            tlen_reg    <= '0;
            dropped_reg <= 1'b0;
            ofs_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                ofs_reg <= cfg_data;
            end
            if (ctl.load)
            begin
                case (in_data.cmd)
                    CMD_PAT_APPEND:
                    begin
                        if (plen_reg < PLEN_W'(PAT_DEPTH))
                        begin
                            plen_reg <= plen_reg + PLEN_W'(1);
                        end
                        else
                        begin
                            dropped_reg <= 1'b1;
                        end
                    end
                    CMD_TXT_APPEND:
                    begin
                        if (tlen_reg < TLEN_W'(TXT_DEPTH))
                        begin
                            tlen_reg <= tlen_reg + TLEN_W'(1);
                        end
                        else
                        begin
                            dropped_reg <= 1'b1;
                        end
                    end
                    CMD_PAT_CLEAR:
                    begin
                        plen_reg    <= '0;
                        dropped_reg <= 1'b0;
                    end
                    default:
                    begin
                        dropped_reg <= dropped_reg;
                    end
                endcase
            end
            if (ctl.out_load)
            begin
                tlen_reg    <= '0;
                dropped_reg <= 1'b0;
            end
        end
    end

    // scan registers
    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            out_reg.matched           <= res_match_reg;
            out_reg.descend_candidate <= res_desc_reg;
            out_reg.overflow          <= dropped_reg;
        end
        if (ctl.start)
        begin
            i_reg        <= I_W'(ofs_reg);
            j_reg        <= J_W'(ofs_reg);
            star_ok_reg  <= 1'b0;
            dstar_ok_reg <= 1'b0;
        end
        case (ctl.op)
            ST_CHAR:
            begin
                if (sts.p_star)
                begin
                    j_reg <= j1;
                end
                else if (sts.p_qm)
                begin
                    if (!sts.t_slash)
                    begin
                        i_reg <= i_reg + I_W'(1);
                        j_reg <= j1;
                    end
                end
                else if (sts.p_lbr)
                begin
                    hit_reg <= 1'b0;
                end
                else if (sts.p_bsl && sts.j1_lt_m)
                begin
                    j_reg <= j1;
                end
                else if (sts.lit_eq)
                begin
                    i_reg <= i_reg + I_W'(1);
                    j_reg <= j1;
                end
            end
            ST_ESC:
            begin
                if (sts.lit_eq)
                begin
                    i_reg <= i_reg + I_W'(1);
                    j_reg <= j1;
                end
            end
            ST_STAR2:
            begin
                if (sts.p_star)
                begin
                    j_reg <= j1;
                    if (!sts.j1_lt_m)
                    begin
                        res_match_reg <= 1'b1;
                        res_desc_reg  <= 1'b1;
                    end
                end
                else if (!sts.t_slash)
                begin
                    star_ok_reg <= 1'b1;
                    star_t_reg  <= i_reg;
                    star_p_reg  <= j_reg;
                end
            end
            ST_DSTAR:
            begin
                j_reg        <= j_reg + J_W'(sts.p_slash);
                dstar_p_reg  <= j_reg + J_W'(sts.p_slash);
                dstar_t_reg  <= i_reg;
                star_ok_reg  <= 1'b0;
                dstar_ok_reg <= 1'b1;
            end
            ST_CLS_NEG:
            begin
                neg_reg       <= neg_c;
                j_reg         <= j1 + J_W'(neg_c);
                hit_reg       <= 1'b0;
                last_none_reg <= 1'b1;
            end
            ST_CLS:
            begin
                if (!sts.j_lt_m || sts.p_rbr)
                begin
                    if (!sts.hit_eq_neg)
                    begin
                        i_reg <= i_reg + I_W'(1);
                        if (sts.j_lt_m)
                        begin
                            j_reg <= j1;
                        end
                    end
                end
                else if (!last_none_reg && sts.p_dash && sts.j1_lt_m)
                begin
                    j_reg <= j1;
                end
                else
                begin
                    if (sts.lit_eq)
                    begin
                        hit_reg <= 1'b1;
                    end
                    last_reg      <= lp;
                    last_none_reg <= 1'b0;
                    j_reg         <= j1;
                end
            end
            ST_CLS_RNG:
            begin
                if (lt <= lp && lt >= last_reg)
                begin
                    hit_reg <= 1'b1;
                end
                last_reg <= lp;
                j_reg    <= j1;
            end
            ST_FAIL:
            begin
                if (star_ok_reg)
                begin
                    star_t_reg <= star_t_inc;
                    i_reg      <= star_t_inc;
                    j_reg      <= star_p_reg;
                end
                else if (dstar_ok_reg)
                begin
                    if (!sts.dp_ge1)
                    begin
                        dstar_t_reg <= dstar_t_inc;
                        i_reg       <= dstar_t_inc;
                        j_reg       <= dstar_p_reg;
                    end
                end
                else
                begin
                    res_match_reg <= 1'b0;
                    res_desc_reg  <= 1'b0;
                end
            end
            ST_STAR_CHK:
            begin
                if (sts.t_slash)
                begin
                    star_ok_reg <= 1'b0;
                end
            end
            ST_DS_CHK:
            begin
                if (!sts.p_slash)
                begin
                    dstar_t_reg <= dstar_t_inc;
                    i_reg       <= dstar_t_inc;
                    j_reg       <= dstar_p_reg;
                end
            end
            ST_DS_RD:
            begin
                if (!sts.ds_lt_n)
                begin
                    dstar_t_reg <= dstar_t_inc;
                    i_reg       <= dstar_t_inc;
                    j_reg       <= dstar_p_reg;
                end
            end
            ST_DS_TST:
            begin
                if (!sts.t_slash)
                begin
                    dstar_t_reg <= dstar_t_inc;
                end
                else
                begin
                    dstar_t_reg <= dstar_t_inc;
                    i_reg       <= dstar_t_inc;
                    j_reg       <= dstar_p_reg;
                end
            end
            ST_TAIL_RD:
            begin
                if (!sts.j_lt_m)
                begin
                    res_match_reg <= 1'b1;
                    res_desc_reg  <= dstar_ok_reg || n_zero;
                end
            end
            ST_TAIL_TST:
            begin
                if (sts.p_star)
                begin
                    j_reg <= j1;
                end
                else
                begin
                    res_match_reg <= 1'b0;
                    res_desc_reg  <= dstar_ok_reg || n_zero || sts.p_slash;
                end
            end
            default:
            begin
                hit_reg <= hit_reg;
            end
        endcase
    end

endmodule

// ----- src/pgm_controller.sv -----
// ----------------------------------------------------------------------------
// path glob matcher controller
// sequences loads and the backtracking match walk, owns the result handshake
// ----------------------------------------------------------------------------
module pgm_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  pgm_pkg::cmd_t     in_cmd,
    input  logic              out_stall,
    input  pgm_pkg::sts_t     sts,
    output pgm_pkg::ctl_t     ctl,
    output logic              in_stall,
    output logic              out_valid
);
    import pgm_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        ctl.op       = state_reg;
        ctl.load     = 1'b0;
        ctl.start    = 1'b0;
        ctl.out_load = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_cmd == CMD_EVAL)
                    begin
                        ctl.start  = 1'b1;
                        state_next = ST_LOOP;
                    end
                    else
                    begin
                        ctl.load = 1'b1;
                    end
                end
            end
            ST_LOOP:
            begin
                if (!sts.i_lt_n)
                begin
                    state_next = ST_TAIL_RD;
                end
                else if (sts.j_lt_m)
                begin
                    state_next = ST_CHAR;
                end
                else
                begin
                    state_next = ST_FAIL;
                end
            end
            ST_CHAR:
            begin
                if (sts.p_star)
                begin
                    state_next = ST_STAR2;
                end
                else if (sts.p_qm)
                begin
                    state_next = sts.t_slash ? ST_FAIL : ST_LOOP;
                end
                else if (sts.p_lbr)
                begin
                    state_next = sts.t_slash ? ST_FAIL : ST_CLS_NEG;
                end
                else if (sts.p_bsl && sts.j1_lt_m)
                begin
                    state_next = ST_ESC;
                end
                else
                begin
                    state_next = sts.lit_eq ? ST_LOOP : ST_FAIL;
                end
            end
            ST_ESC:
            begin
                state_next = sts.lit_eq ? ST_LOOP : ST_FAIL;
            end
            ST_STAR2:
            begin
                if (sts.p_star)
                begin
                    state_next = sts.j1_lt_m ? ST_DSTAR : ST_DONE;
                end
                else
                begin
                    state_next = sts.t_slash ? ST_FAIL : ST_LOOP;
                end
            end
            ST_DSTAR:
            begin
                state_next = ST_LOOP;
            end
            ST_CLS_NEG:
            begin
                state_next = ST_CLS;
            end
            ST_CLS:
            begin
                if (!sts.j_lt_m || sts.p_rbr)
                begin
                    state_next = sts.hit_eq_neg ? ST_FAIL : ST_LOOP;
                end
                else if (!sts.last_none && sts.p_dash && sts.j1_lt_m)
                begin
                    state_next = ST_CLS_RNG;
                end
                else
                begin
                    state_next = ST_CLS;
                end
            end
            ST_CLS_RNG:
            begin
                state_next = ST_CLS;
            end
            ST_FAIL:
            begin
                if (sts.star_ok)
                begin
                    state_next = ST_STAR_CHK;
                end
                else if (sts.dstar_ok)
                begin
                    state_next = sts.dp_ge1 ? ST_DS_CHK : ST_LOOP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_STAR_CHK:
            begin
                state_next = ST_LOOP;
            end
            ST_DS_CHK:
            begin
                state_next = sts.p_slash ? ST_DS_RD : ST_LOOP;
            end
            ST_DS_RD:
            begin
                state_next = sts.ds_lt_n ? ST_DS_TST : ST_LOOP;
            end
            ST_DS_TST:
            begin
                state_next = sts.t_slash ? ST_LOOP : ST_DS_RD;
            end
            ST_TAIL_RD:
            begin
                state_next = sts.j_lt_m ? ST_TAIL_TST : ST_DONE;
            end
            ST_TAIL_TST:
            begin
                state_next = sts.p_star ? ST_TAIL_RD : ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    ctl.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/path_glob_matcher_core.sv -----
// loads: one item per cycle while idle, no result
// evaluate: input stalled from accept until the result loads; each step: LOOP, CHAR,
// then ESC for an escape, STAR2 for *, DSTAR after it for **, CLS_NEG, a CLS per class
// byte; backtrack: FAIL, then STAR_CHK, or DS_CHK and a DS_RD, DS_TST pair per skipped
// text byte; result registered in DONE, later while an earlier result is stalled
// rst_n clears lengths, dropped flag, offset and handshake state; stores keep contents
// ----------------------------------------------------------------------------
// path glob matcher core
// case-insensitive path glob match with one star and one double-star backup
// ----------------------------------------------------------------------------
`include "path_glob_matcher_core_assert.svh"

module path_glob_matcher_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  pgm_pkg::in_item_t    in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output pgm_pkg::out_item_t   out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [6:0]           cfg_data
);
    import pgm_pkg::*;

    ctl_t ctl;
    sts_t sts;

    assign cfg_ready = 1'b1;

    pgm_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_cmd    (in_data.cmd),
        .out_stall (out_stall),
        .sts       (sts),
        .ctl       (ctl),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    pgm_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .in_data  (in_data),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .sts      (sts),
        .out_data (out_data)
    );

    `PGM_ASSERT_NXT(a_eval_holds_input, clk, rst_n, in_valid && !in_stall && in_data.cmd == CMD_EVAL, in_stall)
    `PGM_ASSERT_IMP(a_result_from_done, clk, rst_n, $rose(out_valid), $past(ctl.op) == ST_DONE)
    `PGM_ASSERT_IMP(a_load_only_idle, clk, rst_n, ctl.load || ctl.start, ctl.op == ST_IDLE)

endmodule

// ----- tb/sv/tb_path_glob_matcher_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// path glob matcher core testbench
// loads patterns and path texts through the item port, evaluates them under
// several start offsets and checks every result against an in-bench matcher
// that follows the glob rules, with random idling on both channels
// ----------------------------------------------------------------------------
module tb_path_glob_matcher_core;
    import pgm_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    class glob_scoreboard;
        logic [7:0] pat_mem[PAT_DEPTH];
        logic [7:0] txt_mem[TXT_DEPTH];
        int         pat_len;
        int         txt_len;
        bit         dropped;
        int         offset;
        out_item_t  expected_q[$];
        int         mismatches;

        function new();
            pat_len    = 0;
            txt_len    = 0;
            dropped    = 0;
            offset     = 0;
            mismatches = 0;
        endfunction

        function int pat_at(int k);
            return (k < pat_len) ? int'(pat_mem[k]) : 0;
        endfunction

        function int txt_at(int k);
            return (k < txt_len) ? int'(txt_mem[k]) : 0;
        endfunction

        function int lc(int c);
            return (c >= int'(CH_UA) && c <= int'(CH_UZ)) ? c + 32 : c;
        endfunction

        function void glob_match(output bit mt, output bit dc);
            int n;
            int m;
            int i;
            int j;
            int st;
            int sp;
            int dt;
            int dp;
            int p;
            int t;
            int last;
            int lt;
            bit sok;
            bit dok;
            bit hit;
            bit neg;
            n = txt_len;
            m = pat_len;
            i = offset;
            j = offset;
            sok = 0;
            dok = 0;
            st = 0;
            sp = 0;
            dt = 0;
            dp = 0;
            while (i < n)
            begin
                if (j < m)
                begin
                    p = pat_at(j);
                    t = txt_at(i);
                    if (p == int'(CH_STAR))
                    begin
                        j++;
                        if (j < m && pat_at(j) == int'(CH_STAR))
                        begin
                            j++;
                            if (j >= m)
                            begin
                                mt = 1;
                                dc = 1;
                                return;
                            end
                            if (pat_at(j) == int'(CH_SLASH))
                                j++;
                            sok = 0;
                            dok = 1;
                            dt = i;
                            dp = j;
                            continue;
                        end
                        if (t != int'(CH_SLASH))
                        begin
                            sok = 1;
                            st = i;
                            sp = j;
                            continue;
                        end
                    end
                    else if (p == int'(CH_QMARK))
                    begin
                        if (t != int'(CH_SLASH))
                        begin
                            i++;
                            j++;
                            continue;
                        end
                    end
                    else if (p == int'(CH_LBR))
                    begin
                        if (t != int'(CH_SLASH))
                        begin
                            last = 256;
                            lt = lc(t);
                            hit = 0;
                            neg = (j + 1 < m) && (pat_at(j + 1) == int'(CH_CARET) ||
                                                  pat_at(j + 1) == int'(CH_BANG));
                            if (neg)
                                j++;
                            while (1)
                            begin
                                j++;
                                if (!(j < m) || pat_at(j) == int'(CH_RBR))
                                    break;
                                if (last < 256 && pat_at(j) == int'(CH_DASH) && j + 1 < m)
                                begin
                                    j++;
                                    if (lt <= lc(pat_at(j)) && lt >= last)
                                        hit = 1;
                                end
                                else if (lt == lc(pat_at(j)))
                                begin
                                    hit = 1;
                                end
                                last = lc(pat_at(j));
                            end
                            if (hit != neg)
                            begin
                                i++;
                                if (j < m)
                                    j++;
                                continue;
                            end
                        end
                    end
                    else
                    begin
                        if (p == int'(CH_BSL) && j + 1 < m)
                        begin
                            j++;
                            p = pat_at(j);
                        end
                        if (lc(t) == lc(p))
                        begin
                            i++;
                            j++;
                            continue;
                        end
                    end
                end
                if (sok)
                begin
                    st++;
                    i = st;
                    j = sp;
                    if (st < n && txt_at(st) == int'(CH_SLASH))
                        sok = 0;
                    continue;
                end
                if (dok)
                begin
                    if (dp >= 1 && pat_at(dp - 1) == int'(CH_SLASH))
                        while (dt < n && txt_at(dt) != int'(CH_SLASH))
                            dt++;
                    dt++;
                    i = dt;
                    j = dp;
                    continue;
                end
                mt = 0;
                dc = dok;
                return;
            end
            while (j < m && pat_at(j) == int'(CH_STAR))
                j++;
            mt = (j >= m);
            dc = dok || (n == 0) || (j < m && pat_at(j) == int'(CH_SLASH));
        endfunction

        function void note_item(in_item_t it);
            out_item_t r;
            bit mt;
            bit dc;
            case (it.cmd)
                CMD_PAT_APPEND:
                begin
                    if (pat_len < PAT_DEPTH)
                    begin
                        pat_mem[pat_len] = it.char_byte;
                        pat_len++;
                    end
                    else
                        dropped = 1;
                end
                CMD_TXT_APPEND:
                begin
                    if (txt_len < TXT_DEPTH)
                    begin
                        txt_mem[txt_len] = it.char_byte;
                        txt_len++;
                    end
                    else
                        dropped = 1;
                end
                CMD_PAT_CLEAR:
                begin
                    pat_len = 0;
                    dropped = 0;
                end
                default:
                begin
                    glob_match(mt, dc);
                    r.matched = mt;
                    r.descend_candidate = dc;
                    r.overflow = dropped;
                    expected_q.push_back(r);
                    txt_len = 0;
                    dropped = 0;
                end
            endcase
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp_r;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %b", got);
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.matched !== exp_r.matched ||
                got.descend_candidate !== exp_r.descend_candidate ||
                got.overflow !== exp_r.overflow)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected m=%b d=%b o=%b, got m=%b d=%b o=%b",
                             exp_r.matched, exp_r.descend_candidate, exp_r.overflow,
                             got.matched, got.descend_candidate, got.overflow);
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_stall;
    out_item_t  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [6:0] cfg_data;

    glob_scoreboard sb;
    bit quiet;
    int items_sent;
    int evals_sent;
    int stall_left;

    path_glob_matcher_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // receiver stall bursts
    always @(negedge clk)
    begin
        if (quiet)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 15);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
    end

    task automatic send_item(cmd_t c, logic [7:0] b);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data.cmd = c;
        in_data.char_byte = b;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_item(in_data);
        items_sent++;
        if (c == CMD_EVAL)
            evals_sent++;
        @(negedge clk);
    endtask

    task automatic run_case(byte_q_t pq, byte_q_t tq);
        send_item(CMD_PAT_CLEAR, 8'($urandom));
        foreach (pq[k])
            send_item(CMD_PAT_APPEND, pq[k]);
        foreach (tq[k])
            send_item(CMD_TXT_APPEND, tq[k]);
        send_item(CMD_EVAL, 8'($urandom));
    endtask

    task automatic run_str(string ps, string ts);
        byte_q_t pq;
        byte_q_t tq;
        for (int k = 0; k < ps.len(); k++)
            pq.push_back(ps[k]);
        for (int k = 0; k < ts.len(); k++)
            tq.push_back(ts[k]);
        run_case(pq, tq);
    endtask

    task automatic settle_idle();
        in_valid = 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_offset(logic [6:0] v);
        cfg_valid = 1'b1;
        cfg_data = v;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.offset = int'(v);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [7:0] rand_letter();
        logic [7:0] c;
        c = 8'h61 + 8'($urandom_range(0, 25));
        if ($urandom_range(0, 3) == 0)
            c = c - CASE_OFS;
        return c;
    endfunction

    task automatic random_case();
        byte_q_t pq;
        byte_q_t tq;
        logic [7:0] c;
        int ntok;
        int sel;
        ntok = $urandom_range(1, 7);
        if ($urandom_range(0, 49) == 0)
        begin
            // fill both stores around their depth, overfilling neither, one or both
            repeat ($urandom_range(60, 70)) pq.push_back(rand_letter());
            pq[0] = CH_STAR;
            pq[1] = CH_STAR;
            repeat ($urandom_range(250, 270)) tq.push_back(rand_letter());
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(0, 8)) pq.push_back(8'($urandom));
            repeat ($urandom_range(0, 8)) tq.push_back(8'($urandom));
        end
        else
        begin
            for (int k = 0; k < ntok; k++)
            begin
                sel = $urandom_range(0, 10);
                case (sel)
                    0, 1, 2:
                    begin
                        c = rand_letter();
                        pq.push_back(c);
                        tq.push_back($urandom_range(0, 1) ? c : (c ^ CASE_OFS));
                    end
                    3:
                    begin
                        pq.push_back(CH_SLASH);
                        tq.push_back(CH_SLASH);
                    end
                    4:
                    begin
                        pq.push_back(CH_QMARK);
                        tq.push_back(rand_letter());
                    end
                    5, 6:
                    begin
                        pq.push_back(CH_STAR);
                        repeat ($urandom_range(0, 3)) tq.push_back(rand_letter());
                    end
                    7:
                    begin
                        pq.push_back(CH_STAR);
                        pq.push_back(CH_STAR);
                        if ($urandom_range(0, 1))
                        begin
                            pq.push_back(CH_SLASH);
                            repeat ($urandom_range(0, 2))
                            begin
                                repeat ($urandom_range(1, 2)) tq.push_back(rand_letter());
                                tq.push_back(CH_SLASH);
                            end
                        end
                        else
                            repeat ($urandom_range(0, 4))
                                tq.push_back($urandom_range(0, 2) ? rand_letter() : CH_SLASH);
                    end
                    8:
                    begin
                        pq.push_back(CH_LBR);
                        if ($urandom_range(0, 1))
                            pq.push_back($urandom_range(0, 1) ? CH_BANG : CH_CARET);
                        pq.push_back(rand_letter());
                        if ($urandom_range(0, 1))
                        begin
                            pq.push_back(CH_DASH);
                            pq.push_back(rand_letter());
                        end
                        if ($urandom_range(0, 7) != 0)
                            pq.push_back(CH_RBR);
                        tq.push_back(rand_letter());
                    end
                    default:
                    begin
                        c = $urandom_range(0, 1) ? CH_STAR : CH_LBR;
                        pq.push_back(CH_BSL);
                        pq.push_back(c);
                        tq.push_back(c);
                    end
                endcase
            end
            if ($urandom_range(0, 3) == 0 && tq.size() > 0)
                tq[$urandom_range(0, tq.size() - 1)] = $urandom_range(0, 1) ? CH_SLASH
                                                                           : 8'($urandom);
            if ($urandom_range(0, 7) == 0 && tq.size() > 0)
                void'(tq.pop_back());
        end
        run_case(pq, tq);
    endtask

    initial
    begin
        logic [6:0] offsets[6];
        sb = new();
        quiet = 1'b0;
        items_sent = 0;
        evals_sent = 0;
        stall_left = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        run_str("", "");
        run_str("a*b", "AxXb");
        run_str("a*", "ab/c");
        run_str("**/x", "a/b/x");
        run_str("a/**", "a/b/c");
        run_str("?", "/");
        run_str("[!a-c]", "d");
        run_str("[^a-c]x", "bx");
        run_str("[a", "a");
        run_str("ab\\", "ab\\");
        run_str("\\*", "*");
        run_str("a/", "");
        run_case('{8'hFF, 8'h00}, '{8'hff, 8'h00});
        run_case('{8'h7F}, '{8'h80});

        offsets = '{7'd0, 7'd1, 7'd64, 7'd2, 7'd3, 7'd0};
        for (int ph = 0; ph < 6; ph++)
        begin
            settle_idle();
            write_offset(offsets[ph]);
            if (ph == 5)
                quiet = 1'b1;
            for (int k = 0; k < 6; k++)
                random_case();
        end
        while (items_sent < 900 || evals_sent < 60)
            random_case();
        in_valid = 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
